// ===== src/cct_pkg.sv =====
// ----------------------------------------------------------------------------
// cct_pkg: shared types and constants for the capsule query unit
// Coordinate widths, derived product widths, opcode and register codes,
// and the capsule configuration record.
// ----------------------------------------------------------------------------
package cct_pkg;

	// field widths
	localparam int COORD_W = 24;            // signed Q.8 coordinate
	localparam int BOX_W   = 16;            // signed integer box corner
	localparam int RAD_W   = COORD_W - 1;   // unsigned Q.8 radius
	localparam int FRAC_W  = 8;
	localparam int IDX_W   = 3;

	// pipeline: five arithmetic stages plus the output register
	localparam int PIPE_DEPTH = 6;

	// derived widths of the sphere datapath
	localparam int DIFF_W = COORD_W + 1;        // ball - origin
	localparam int EDGE_W = COORD_W + 2;        // ball - origin - span
	localparam int PT_W   = COORD_W + 3;        // extended endpoints
	localparam int SQW_W  = 2 * COORD_W;        // one square of w
	localparam int SQD_W  = 2 * COORD_W - 1;    // one square of d
	localparam int SQV_W  = 2 * COORD_W + 2;    // one square of w - d
	localparam int PWD_W  = DIFF_W + COORD_W;   // one signed w*d term
	localparam int RR_W   = 2 * COORD_W;        // summed radius squared
	localparam int WW_W   = 2 * COORD_W + 2;    // |w|^2
	localparam int DD_W   = 2 * COORD_W;        // |d|^2
	localparam int DW_W   = 2 * COORD_W + 2;    // d.w, signed
	localparam int EE_W   = 2 * COORD_W + 4;    // |w - d|^2
	localparam int PP_W   = 2 * COORD_W + 2;    // one partial product
	localparam int PROD_W = 4 * COORD_W + 2;    // wide cross products

	typedef enum logic [1:0] {
		OP_SPHERE   = 2'd0,
		OP_NEAR_BOX = 2'd1,
		OP_IN_BOX   = 2'd2,
		OP_NONE     = 2'd3
	} opcode_t;

	typedef enum logic [IDX_W-1:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_SPAN_X   = 3'd3,
		REG_SPAN_Y   = 3'd4,
		REG_SPAN_Z   = 3'd5,
		REG_RADIUS   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] origin_x;
		logic signed [COORD_W-1:0] origin_y;
		logic signed [COORD_W-1:0] origin_z;
		logic signed [COORD_W-1:0] span_x;
		logic signed [COORD_W-1:0] span_y;
		logic signed [COORD_W-1:0] span_z;
		logic        [RAD_W-1:0]   radius;
	} capsule_t;

	typedef struct packed {
		logic near;        // extended bounding box overlaps the box
		logic contained;   // both extended endpoints lie in the box
	} box_res_t;

endpackage

// ===== src/cct_box.sv =====
// ----------------------------------------------------------------------------
// cct_box: box tests against the radius-extended segment
// Builds both extended endpoints per axis and evaluates the overlap test
// (endpoints truncated toward zero) and the containment test (exact Q.8).
// ----------------------------------------------------------------------------
module cct_box (
	input  cct_pkg::capsule_t                     cap,
	input  logic signed [cct_pkg::BOX_W-1:0]      box_min_x,
	input  logic signed [cct_pkg::BOX_W-1:0]      box_min_y,
	input  logic signed [cct_pkg::BOX_W-1:0]      box_min_z,
	input  logic signed [cct_pkg::BOX_W-1:0]      box_max_x,
	input  logic signed [cct_pkg::BOX_W-1:0]      box_max_y,
	input  logic signed [cct_pkg::BOX_W-1:0]      box_max_z,
	output cct_pkg::box_res_t                     res
);
	import cct_pkg::*;

	localparam int INT_W = PT_W - FRAC_W;

	logic signed [COORD_W-1:0] org [3];
	logic signed [COORD_W-1:0] spn [3];
	logic signed [BOX_W-1:0]   bmn [3];
	logic signed [BOX_W-1:0]   bmx [3];
	logic signed [PT_W-1:0]    rad;
	logic signed [PT_W-1:0]    ext [3];
	logic signed [PT_W-1:0]    pa  [3];
	logic signed [PT_W-1:0]    pb  [3];
	logic signed [PT_W-1:0]    plo [3];
	logic signed [PT_W-1:0]    phi [3];
	logic signed [INT_W-1:0]   ilo [3];
	logic signed [INT_W-1:0]   ihi [3];
	logic signed [PT_W-1:0]    qmn [3];
	logic signed [PT_W-1:0]    qmx [3];
	logic [2:0]                near_ax;
	logic [2:0]                in_ax;

	// signed divide by 256, rounding toward zero
	function automatic logic signed [INT_W-1:0] trunc0(input logic signed [PT_W-1:0] x);
		logic signed [INT_W-1:0] q;
		q = x[PT_W-1:FRAC_W];
		if (x[PT_W-1] && (x[FRAC_W-1:0] != '0)) begin
			q = q + INT_W'(1);
		end
		return q;
	endfunction

	always_comb begin
		org[0] = cap.origin_x;  org[1] = cap.origin_y;  org[2] = cap.origin_z;
		spn[0] = cap.span_x;    spn[1] = cap.span_y;    spn[2] = cap.span_z;
		bmn[0] = box_min_x;     bmn[1] = box_min_y;     bmn[2] = box_min_z;
		bmx[0] = box_max_x;     bmx[1] = box_max_y;     bmx[2] = box_max_z;
	end

	assign rad = $signed({{(PT_W - RAD_W){1'b0}}, cap.radius});

	// per-axis endpoints and tests
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ext[i] = spn[i][COORD_W-1] ? -rad : rad;
			pa[i]  = PT_W'(org[i]) - ext[i];
			pb[i]  = PT_W'(org[i]) + PT_W'(spn[i]) + ext[i];
			plo[i] = (pa[i] < pb[i]) ? pa[i] : pb[i];
			phi[i] = (pa[i] < pb[i]) ? pb[i] : pa[i];
			ilo[i] = trunc0(plo[i]);
			ihi[i] = trunc0(phi[i]);
			near_ax[i] = (ilo[i] <= INT_W'(bmx[i])) && (ihi[i] >= INT_W'(bmn[i]));
			qmn[i] = PT_W'($signed({bmn[i], {FRAC_W{1'b0}}}));
			qmx[i] = PT_W'($signed({bmx[i], {FRAC_W{1'b0}}}));
			in_ax[i] = (pa[i] >= qmn[i]) && (pa[i] <= qmx[i])
				&& (pb[i] >= qmn[i]) && (pb[i] <= qmx[i]);
		end
	end

	assign res.near      = &near_ax;
	assign res.contained = &in_ax;

endmodule

// ===== src/cct_sphere.sv =====
// ----------------------------------------------------------------------------
// cct_sphere: five-stage capsule versus sphere datapath
// Differences, squares and dot products, sums, split wide multiplies,
// then the exact cross-multiplied distance compare. All stages move on en.
// ----------------------------------------------------------------------------
module cct_sphere (
	input  logic                                clk,
	input  logic                                en,
	input  cct_pkg::capsule_t                   cap,
	input  logic signed [cct_pkg::COORD_W-1:0]  ball_x,
	input  logic signed [cct_pkg::COORD_W-1:0]  ball_y,
	input  logic signed [cct_pkg::COORD_W-1:0]  ball_z,
	input  logic        [cct_pkg::RAD_W-1:0]    ball_radius,
	output logic                                hit
);
	import cct_pkg::*;

	logic signed [COORD_W-1:0] org [3];
	logic signed [COORD_W-1:0] spn [3];
	logic signed [COORD_W-1:0] bal [3];

	// stage 1
	logic signed [DIFF_W-1:0]  w_s1 [3];
	logic signed [EDGE_W-1:0]  v_s1 [3];
	logic signed [COORD_W-1:0] d_s1 [3];
	logic        [COORD_W-1:0] rsum_s1;

	// stage 2
	logic signed [2*DIFF_W-1:0]  mw  [3];
	logic signed [2*COORD_W-1:0] md  [3];
	logic signed [PWD_W-1:0]     mwd [3];
	logic signed [2*EDGE_W-1:0]  mv  [3];
	logic        [RR_W-1:0]      mr;
	logic        [SQW_W-1:0]     sqw_s2 [3];
	logic        [SQD_W-1:0]     sqd_s2 [3];
	logic signed [PWD_W-1:0]     pwd_s2 [3];
	logic        [SQV_W-1:0]     sqv_s2 [3];
	logic        [RR_W-1:0]      rr_s2;

	// stage 3
	logic        [WW_W-1:0] ww_s3;
	logic        [DD_W-1:0] dd_s3;
	logic signed [DW_W-1:0] dw_s3;
	logic        [EE_W-1:0] ee_s3;
	logic        [RR_W-1:0] rr_s3;

	// stage 4
	logic [WW_W-COORD_W-1:0] wh;
	logic [COORD_W-1:0]      wl, dh, dl, rh, rl, mh, ml;
	logic [PP_W-1:0]         plhs_s4 [4];
	logic [PP_W-1:0]         prd_s4  [4];
	logic [PP_W-1:0]         psq_s4  [3];
	logic                    org_s4, end_s4, hito_s4, hite_s4;

	// stage 5
	logic [PROD_W-1:0] lhs_s5, rd_s5, sq_s5;
	logic              org_s5, end_s5, hito_s5, hite_s5;
	logic [PROD_W-1:0] rhs;

	always_comb begin
		org[0] = cap.origin_x;  org[1] = cap.origin_y;  org[2] = cap.origin_z;
		spn[0] = cap.span_x;    spn[1] = cap.span_y;    spn[2] = cap.span_z;
		bal[0] = ball_x;        bal[1] = ball_y;        bal[2] = ball_z;
	end

	// stage 1: offsets from the segment start and end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				w_s1[i] <= DIFF_W'(bal[i]) - DIFF_W'(org[i]);
				v_s1[i] <= EDGE_W'(bal[i]) - EDGE_W'(org[i]) - EDGE_W'(spn[i]);
				d_s1[i] <= spn[i];
			end
			rsum_s1 <= COORD_W'(ball_radius) + COORD_W'(cap.radius);
		end
	end

	// stage 2: one multiplier per term
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mw[i]  = w_s1[i] * w_s1[i];
			md[i]  = d_s1[i] * d_s1[i];
			mwd[i] = PWD_W'(w_s1[i]) * PWD_W'(d_s1[i]);
			mv[i]  = v_s1[i] * v_s1[i];
		end
		mr = RR_W'(rsum_s1) * RR_W'(rsum_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sqw_s2[i] <= mw[i][SQW_W-1:0];
				sqd_s2[i] <= md[i][SQD_W-1:0];
				pwd_s2[i] <= mwd[i];
				sqv_s2[i] <= mv[i][SQV_W-1:0];
			end
			rr_s2 <= mr;
		end
	end

	// stage 3: three-term sums
	always_ff @(posedge clk) begin
		if (en) begin
			ww_s3 <= WW_W'(sqw_s2[0]) + WW_W'(sqw_s2[1]) + WW_W'(sqw_s2[2]);
			dd_s3 <= DD_W'(sqd_s2[0]) + DD_W'(sqd_s2[1]) + DD_W'(sqd_s2[2]);
			dw_s3 <= DW_W'(pwd_s2[0]) + DW_W'(pwd_s2[1]) + DW_W'(pwd_s2[2]);
			ee_s3 <= EE_W'(sqv_s2[0]) + EE_W'(sqv_s2[1]) + EE_W'(sqv_s2[2]);
			rr_s3 <= rr_s2;
		end
	end

	// stage 4: clamp decisions and split partial products
	// when the closest point lies strictly between the segment ends,
	// 0 < d.w < |d|^2, so the low bits of d.w hold it exactly
	assign wh = ww_s3[WW_W-1:COORD_W];
	assign wl = ww_s3[COORD_W-1:0];
	assign dh = dd_s3[DD_W-1:COORD_W];
	assign dl = dd_s3[COORD_W-1:0];
	assign rh = rr_s3[RR_W-1:COORD_W];
	assign rl = rr_s3[COORD_W-1:0];
	assign mh = dw_s3[2*COORD_W-1:COORD_W];
	assign ml = dw_s3[COORD_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			org_s4  <= dw_s3[DW_W-1] || (dw_s3 == '0);
			end_s4  <= $unsigned(dw_s3) >= DW_W'(dd_s3);
			hito_s4 <= ww_s3 <= WW_W'(rr_s3);
			hite_s4 <= ee_s3 <= EE_W'(rr_s3);
			plhs_s4[0] <= PP_W'(wh) * PP_W'(dh);
			plhs_s4[1] <= PP_W'(wh) * PP_W'(dl);
			plhs_s4[2] <= PP_W'(wl) * PP_W'(dh);
			plhs_s4[3] <= PP_W'(wl) * PP_W'(dl);
			prd_s4[0]  <= PP_W'(rh) * PP_W'(dh);
			prd_s4[1]  <= PP_W'(rh) * PP_W'(dl);
			prd_s4[2]  <= PP_W'(rl) * PP_W'(dh);
			prd_s4[3]  <= PP_W'(rl) * PP_W'(dl);
			psq_s4[0]  <= PP_W'(mh) * PP_W'(mh);
			psq_s4[1]  <= PP_W'(mh) * PP_W'(ml);
			psq_s4[2]  <= PP_W'(ml) * PP_W'(ml);
		end
	end

	// stage 5: recombine partial products
	always_ff @(posedge clk) begin
		if (en) begin
			lhs_s5 <= (PROD_W'(plhs_s4[0]) << (2 * COORD_W))
				+ (PROD_W'(plhs_s4[1]) << COORD_W)
				+ (PROD_W'(plhs_s4[2]) << COORD_W)
				+ PROD_W'(plhs_s4[3]);
			rd_s5  <= (PROD_W'(prd_s4[0]) << (2 * COORD_W))
				+ (PROD_W'(prd_s4[1]) << COORD_W)
				+ (PROD_W'(prd_s4[2]) << COORD_W)
				+ PROD_W'(prd_s4[3]);
			sq_s5  <= (PROD_W'(psq_s4[0]) << (2 * COORD_W))
				+ (PROD_W'(psq_s4[1]) << (COORD_W + 1))
				+ PROD_W'(psq_s4[2]);
			org_s5  <= org_s4;
			end_s5  <= end_s4;
			hito_s5 <= hito_s4;
			hite_s5 <= hite_s4;
		end
	end

	// final compare: |w|^2 |d|^2 <= R^2 |d|^2 + (d.w)^2
	assign rhs = rd_s5 + sq_s5;

	always_comb begin
		if (org_s5) begin
			hit = hito_s5;
		end else if (end_s5) begin
			hit = hite_s5;
		end else begin
			hit = lhs_s5 <= rhs;
		end
	end

endmodule

// ===== src/capsule_collision_tests_unit.sv =====
// ----------------------------------------------------------------------------
// capsule_collision_tests_unit: capsule query pipeline
//
//   channel   dir   handshake              payload
//   cfg       in    cfg_we                 cfg_index, cfg_data
//   in        in    in_valid / in_stall    opcode, ball_*, box_min_*, box_max_*
//   out       out   out_valid / out_stall  hit
//
// One item per cycle while no output is held; each result passes the five
// arithmetic stages of the sphere datapath and the output register after
// its item is accepted. out_stall on a valid output freezes every stage
// together, so in_stall follows a held output. Reset empties the pipeline
// and clears the capsule registers; there is no clearing pass.
// ----------------------------------------------------------------------------
module capsule_collision_tests_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [cct_pkg::IDX_W-1:0]           cfg_index,
	input  logic [cct_pkg::COORD_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          opcode,
	input  logic signed [cct_pkg::COORD_W-1:0]  ball_x,
	input  logic signed [cct_pkg::COORD_W-1:0]  ball_y,
	input  logic signed [cct_pkg::COORD_W-1:0]  ball_z,
	input  logic        [cct_pkg::RAD_W-1:0]    ball_radius,
	input  logic signed [cct_pkg::BOX_W-1:0]    box_min_x,
	input  logic signed [cct_pkg::BOX_W-1:0]    box_min_y,
	input  logic signed [cct_pkg::BOX_W-1:0]    box_min_z,
	input  logic signed [cct_pkg::BOX_W-1:0]    box_max_x,
	input  logic signed [cct_pkg::BOX_W-1:0]    box_max_y,
	input  logic signed [cct_pkg::BOX_W-1:0]    box_max_z,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                hit
);
	import cct_pkg::*;

	capsule_t              cap_q;
	box_res_t              box_res;
	logic                  sph_hit;
	logic                  en;
	logic                  pre_hit;
	logic [PIPE_DEPTH:1]   valid_s;
	opcode_t               op_s  [1:PIPE_DEPTH];
	logic                  pre_s [1:PIPE_DEPTH-1];
	logic                  hit_s6;

	// capsule registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ORIGIN_X: cap_q.origin_x <= cfg_data;
				REG_ORIGIN_Y: cap_q.origin_y <= cfg_data;
				REG_ORIGIN_Z: cap_q.origin_z <= cfg_data;
				REG_SPAN_X:   cap_q.span_x   <= cfg_data;
				REG_SPAN_Y:   cap_q.span_y   <= cfg_data;
				REG_SPAN_Z:   cap_q.span_z   <= cfg_data;
				REG_RADIUS:   cap_q.radius   <= cfg_data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	// whole pipeline advances unless the output item is held
	assign en       = !(valid_s[PIPE_DEPTH] && out_stall);
	assign in_stall = !en;

	cct_box u_box (
		.cap       (cap_q),
		.box_min_x (box_min_x),
		.box_min_y (box_min_y),
		.box_min_z (box_min_z),
		.box_max_x (box_max_x),
		.box_max_y (box_max_y),
		.box_max_z (box_max_z),
		.res       (box_res)
	);

	cct_sphere u_sphere (
		.clk         (clk),
		.en          (en),
		.cap         (cap_q),
		.ball_x      (ball_x),
		.ball_y      (ball_y),
		.ball_z      (ball_z),
		.ball_radius (ball_radius),
		.hit         (sph_hit)
	);

	// box answer picked by opcode, carried beside the sphere datapath
	always_comb begin
		case (opcode_t'(opcode))
			OP_NEAR_BOX: pre_hit = box_res.near;
			OP_IN_BOX:   pre_hit = box_res.contained;
			default:     pre_hit = 1'b0;
		endcase
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[PIPE_DEPTH-1:1], in_valid};
		end
	end

	// per-item side data and output register
	always_ff @(posedge clk) begin
		if (en) begin
			op_s[1]  <= opcode_t'(opcode);
			pre_s[1] <= pre_hit;
			for (int k = 2; k < PIPE_DEPTH; k++) begin
				op_s[k]  <= op_s[k-1];
				pre_s[k] <= pre_s[k-1];
			end
			op_s[PIPE_DEPTH] <= op_s[PIPE_DEPTH-1];
			hit_s6 <= (op_s[PIPE_DEPTH-1] == OP_SPHERE) ? sph_hit : pre_s[PIPE_DEPTH-1];
		end
	end

	assign out_valid = valid_s[PIPE_DEPTH];
	assign hit       = hit_s6;

	// a held output freezes every stage
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(valid_s) && $stable(hit)))
		else $error("pipeline moved while output held");

	// an accepted item enters stage one
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s[1])
		else $error("accepted item lost at pipeline entry");

	// valid bits shift one stage when not stalled
	a_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_stall) |=> (valid_s[PIPE_DEPTH] == $past(valid_s[PIPE_DEPTH-1])))
		else $error("valid bit did not advance");

	// the unused opcode never reports a hit
	a_nop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (op_s[PIPE_DEPTH] == OP_NONE)) |-> !hit)
		else $error("hit on unused opcode");

endmodule

// ===== dv/tb_capsule_collision_tests_unit.sv =====
// ----------------------------------------------------------------------------
// tb_capsule_collision_tests_unit: self-checking bench for the capsule query unit
// Loads several capsules through the register port. The capsules get
// directed or random sphere, near-box and in-box queries. A local predictor
// works out the expected hit with exact wide arithmetic, and a monitor
// checks the results in order.
// ----------------------------------------------------------------------------
module tb_capsule_collision_tests_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import cct_pkg::*;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		opcode_t                   op;
		logic signed [COORD_W-1:0] ball [3];
		logic        [RAD_W-1:0]   ball_rad;
		logic signed [BOX_W-1:0]   bmin [3];
		logic signed [BOX_W-1:0]   bmax [3];
	} query_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [COORD_W-1:0] cfg_data;
	logic in_valid, in_stall, out_valid, out_stall, hit;
	logic [1:0] opcode;
	logic signed [COORD_W-1:0] ball_x, ball_y, ball_z;
	logic [RAD_W-1:0] ball_radius;
	logic signed [BOX_W-1:0] box_min_x, box_min_y, box_min_z;
	logic signed [BOX_W-1:0] box_max_x, box_max_y, box_max_z;

	// capsule copy kept by the bench
	longint cap_org [3];
	longint cap_span [3];
	longint cap_rad;

	query_t query_q [$];
	logic   hit_q [$];
	bit     idle_on;
	int     n_err, n_acc_in, n_acc_out, n_hits, n_idle, watchdog;
	int     n_op [4];

	capsule_collision_tests_unit dut (.*);

	// clock
	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// expected hit for one query against the current capsule
	function automatic logic capsule_hit(query_t q);
		longint o, d, c, ext, a, b, lo, hi, mn, mx;
		wide_t w, ww, dd, dw, ee, rr, rs;
		logic h;
		h = 1'b1;
		ww = 0; dd = 0; dw = 0; ee = 0;
		rs = wide_t'(cap_rad) + wide_t'({1'b0, q.ball_rad});
		rr = rs * rs;
		for (int i = 0; i < 3; i++) begin
			o = cap_org[i];
			d = cap_span[i];
			c = longint'(q.ball[i]);
			mn = longint'(q.bmin[i]);
			mx = longint'(q.bmax[i]);
			ext = (d < 0) ? -cap_rad : cap_rad;
			a = o - ext;
			b = o + d + ext;
			w = c - o;
			ww += w * w;
			dd += wide_t'(d) * wide_t'(d);
			dw += w * wide_t'(d);
			ee += (w - wide_t'(d)) * (w - wide_t'(d));
			if (q.op == OP_NEAR_BOX) begin
				lo = ((a < b) ? a : b) / 256;
				hi = ((a > b) ? a : b) / 256;
				if (!(lo <= mx && hi >= mn)) h = 1'b0;
			end else if (q.op == OP_IN_BOX) begin
				if (!(a >= mn * 256 && a <= mx * 256 && b >= mn * 256 && b <= mx * 256))
					h = 1'b0;
			end
		end
		case (q.op)
			OP_SPHERE: begin
				if (dw <= 0) h = (ww <= rr);
				else if (dw >= dd) h = (ee <= rr);
				else h = (ww * dd <= rr * dd + dw * dw);
			end
			OP_NONE: h = 1'b0;
			default: ;
		endcase
		return h;
	endfunction

	// input driver: holds the payload until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) n_acc_in++;
			if (!in_valid || !in_stall) begin
				if (query_q.size() > 0 && !(idle_on && $urandom_range(99) < 14)) begin
					query_t q;
					q = query_q.pop_front();
					hit_q.push_back(capsule_hit(q));
					n_op[q.op]++;
					in_valid    <= 1'b1;
					opcode      <= q.op;
					ball_x      <= q.ball[0];
					ball_y      <= q.ball[1];
					ball_z      <= q.ball[2];
					ball_radius <= q.ball_rad;
					box_min_x   <= q.bmin[0];
					box_min_y   <= q.bmin[1];
					box_min_z   <= q.bmin[2];
					box_max_x   <= q.bmax[0];
					box_max_y   <= q.bmax[1];
					box_max_z   <= q.bmax[2];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic report_mismatch(string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		n_err++;
	endtask

	// result monitor and output stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				n_acc_out++;
				if (hit_q.size() == 0) begin
					report_mismatch("result with nothing expected");
				end else begin
					logic e;
					e = hit_q.pop_front();
					n_hits += hit;
					if (hit !== e)
						report_mismatch($sformatf("result %0d hit %b, expected %b",
							n_acc_out, hit, e));
				end
			end
			out_stall <= idle_on && ($urandom_range(99) < 14);
		end
	end

	// watchdog on cycles without any item moving
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			watchdog <= 0;
		else
			watchdog <= watchdog + 1;
		if (watchdog > 5000) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic write_reg(reg_idx_t idx, longint val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[COORD_W-1:0];
		if (idx == REG_RADIUS) cap_rad = val & ((64'd1 << RAD_W) - 1);
		else if (idx <= REG_ORIGIN_Z) cap_org[idx] = longint'($signed(val[COORD_W-1:0]));
		else cap_span[idx - REG_SPAN_X] = longint'($signed(val[COORD_W-1:0]));
	endtask

	task automatic load_capsule(longint ox, oy, oz, sx, sy, sz, r);
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_ORIGIN_Z, oz);
		write_reg(REG_SPAN_X, sx);
		write_reg(REG_SPAN_Y, sy);
		write_reg(REG_SPAN_Z, sz);
		write_reg(REG_RADIUS, r);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// drain: waits until every query is sent and every result is back, then lets the pipeline settle
	task automatic drain();
		while (query_q.size() > 0 || in_valid || hit_q.size() > 0) @(posedge clk);
		repeat (PIPE_DEPTH + 4) @(posedge clk);
	endtask

	function automatic longint rand_coord();
		case ($urandom_range(5))
			0: return longint'($signed(24'($urandom)));
			1: return $urandom_range(1) ? 8388607 : -8388608;
			default: return longint'($urandom_range(8000)) - 4000;
		endcase
	endfunction

	function automatic longint clamp_box(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// random query, mostly aimed near the capsule so both outcomes occur
	function automatic query_t rand_query();
		query_t q;
		longint p, e, lo, hi, n;
		q.op = ($urandom_range(15) == 0) ? OP_NONE : opcode_t'($urandom_range(2));
		q.ball_rad = ($urandom_range(3) == 0) ? RAD_W'($urandom) : RAD_W'($urandom_range(3000));
		for (int i = 0; i < 3; i++) begin
			n = longint'($urandom_range(600)) - 300;
			if ($urandom_range(4) == 0) begin
				q.ball[i] = 24'(rand_coord());
			end else begin
				p = cap_org[i] + (cap_span[i] * longint'($urandom_range(4))) / 4 + n;
				q.ball[i] = 24'(p);
			end
			e = (cap_span[i] < 0) ? -cap_rad : cap_rad;
			lo = (cap_org[i] - e) / 256;
			hi = (cap_org[i] + cap_span[i] + e) / 256;
			if (lo > hi) begin p = lo; lo = hi; hi = p; end
			if ($urandom_range(4) == 0) begin
				q.bmin[i] = 16'($urandom);
				q.bmax[i] = 16'($urandom);
			end else begin
				q.bmin[i] = 16'(clamp_box(lo - longint'($urandom_range(4)) + 1));
				q.bmax[i] = 16'(clamp_box(hi + longint'($urandom_range(4)) - 1));
			end
		end
		return q;
	endfunction

	function automatic query_t make_query(opcode_t op, longint bx, by, bz, br,
			longint mn, mx);
		query_t q;
		q.op = op;
		q.ball[0] = 24'(bx); q.ball[1] = 24'(by); q.ball[2] = 24'(bz);
		q.ball_rad = RAD_W'(br);
		for (int i = 0; i < 3; i++) begin
			q.bmin[i] = 16'(mn);
			q.bmax[i] = 16'(mx);
		end
		return q;
	endfunction

	task automatic random_phase(int n_items);
		repeat (n_items) query_q.push_back(rand_query());
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0; out_stall = 1'b0;
		opcode = '0; ball_x = '0; ball_y = '0; ball_z = '0; ball_radius = '0;
		box_min_x = '0; box_min_y = '0; box_min_z = '0;
		box_max_x = '0; box_max_y = '0; box_max_z = '0;
		cap_org = '{0, 0, 0}; cap_span = '{0, 0, 0}; cap_rad = 0;
		idle_on = 1'b1;
		watchdog = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset capsule: a point at the origin
		query_q.push_back(make_query(OP_SPHERE, 0, 0, 0, 0, 0, 0));
		query_q.push_back(make_query(OP_SPHERE, 1, 0, 0, 0, 0, 0));
		query_q.push_back(make_query(OP_NEAR_BOX, 0, 0, 0, 0, 0, 0));
		query_q.push_back(make_query(OP_IN_BOX, 0, 0, 0, 0, 0, 0));
		query_q.push_back(make_query(OP_IN_BOX, 0, 0, 0, 0, 1, -1));
		drain();

		// directed: segment along x, length 4, radius 1
		load_capsule(0, 0, 0, 1024, 0, 0, 256);
		query_q.push_back(make_query(OP_SPHERE, 512, 512, 0, 0, 0, 0));      // distance 2, out
		query_q.push_back(make_query(OP_SPHERE, 512, 513, 0, 0, 0, 0));      // distance 2 + 1/256, out
		query_q.push_back(make_query(OP_SPHERE, -300, 0, 0, 44, 0, 0));      // before start
		query_q.push_back(make_query(OP_SPHERE, 1500, 0, 0, 219, 0, 0));     // past end
		query_q.push_back(make_query(OP_SPHERE, 1500, 0, 0, 220, 0, 0));
		query_q.push_back(make_query(OP_SPHERE, -8388608, -8388608, -8388608,
			8388607, 0, 0));
		query_q.push_back(make_query(OP_SPHERE, 8388607, 8388607, 8388607, 0, 0, 0));
		query_q.push_back(make_query(OP_NEAR_BOX, 0, 0, 0, 0, -1, 5));
		query_q.push_back(make_query(OP_NEAR_BOX, 0, 0, 0, 0, 6, 9));
		query_q.push_back(make_query(OP_NEAR_BOX, 0, 0, 0, 0, -32768, 32767));
		query_q.push_back(make_query(OP_NEAR_BOX, 0, 0, 0, 0, 3, -3));       // inverted
		query_q.push_back(make_query(OP_IN_BOX, 0, 0, 0, 0, -1, 5));
		query_q.push_back(make_query(OP_IN_BOX, 0, 0, 0, 0, -1, 4));
		query_q.push_back(make_query(OP_IN_BOX, 0, 0, 0, 0, -32768, 32767));
		query_q.push_back(make_query(OP_NONE, 0, 0, 0, 0, -32768, 32767));
		drain();

		// negative span and fractional truncation toward zero
		load_capsule(-300, 300, -10, -700, 500, -8388608, 100);
		query_q.push_back(make_query(OP_NEAR_BOX, 0, 0, 0, 0, -32768, -2));
		query_q.push_back(make_query(OP_IN_BOX, 0, 0, 0, 0, -32768, 32767));
		random_phase(60);

		// extremes, the first with no idling on either side
		idle_on = 1'b0;
		load_capsule(8388607, -8388608, 8388607, -8388608, 8388607, 8388607, 8388607);
		random_phase(70);
		idle_on = 1'b1;
		load_capsule(-8388608, 8388607, -8388608, 8388607, -8388608, -8388608, 0);
		random_phase(70);

		// zero span with radius
		load_capsule(1000, -2000, 3000, 0, 0, 0, 1200);
		random_phase(70);

		// random capsules
		repeat (3) begin
			load_capsule(rand_coord(), rand_coord(), rand_coord(),
				rand_coord(), rand_coord(), rand_coord(),
				($urandom_range(3) == 0) ? $urandom_range(8388607) : $urandom_range(2000));
			random_phase(75);
		end

		repeat (PIPE_DEPTH + 10) @(posedge clk);
		$display("ran %0d queries (sphere %0d, near %0d, inside %0d, unused %0d)",
			n_acc_in, n_op[0], n_op[1], n_op[2], n_op[3]);
		$display("checked %0d results, %0d hits, %0d mismatches", n_acc_out, n_hits, n_err);
		if (n_err == 0 && hit_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
